FILE: src/sbcd_pkg.sv
// Shared types and constants for the serial bus CD changer responder.
package sbcd_pkg;

    // Byte values that appear on the bus
    localparam logic [7:0] BYTE_IDLE   = 8'hFF;
    localparam logic [7:0] REPLY_ACK   = 8'h00;
    localparam logic [7:0] REPLY_ID    = 8'hEE;
    localparam logic [7:0] MODE_STOP   = 8'h02;
    localparam logic [7:0] MODE_PLAY   = 8'h08;

    localparam logic [7:0] HDR_ARM_A   = 8'h07;
    localparam logic [7:0] HDR_ARM_B   = 8'h00;
    localparam logic [7:0] ADDR_A0     = 8'hE8;
    localparam logic [7:0] ADDR_A1     = 8'hE9;
    localparam logic [7:0] ID_MAIN_0   = 8'h1A;
    localparam logic [7:0] ID_MAIN_1   = 8'h4A;
    localparam logic [7:0] ID_ALT_0    = 8'h1C;
    localparam logic [7:0] ID_ALT_1    = 8'h4C;
    localparam logic [7:0] ID_CART_0   = 8'h1E;
    localparam logic [7:0] ID_CART_1   = 8'h4E;
    localparam logic [7:0] ID_PWR_0    = 8'h19;
    localparam logic [7:0] ID_PWR_1    = 8'h49;
    localparam logic [7:0] ID_TRK_0    = 8'h1B;
    localparam logic [7:0] ID_TRK_1    = 8'h4B;
    localparam logic [7:0] OP_ARM_MAIN = 8'hEE;
    localparam logic [7:0] OP_ARM_ALT  = 8'hED;
    localparam logic [7:0] OP_CART     = 8'hEF;
    localparam logic [7:0] OP_PWR_DOWN = 8'h22;
    localparam logic [7:0] OP_START    = 8'h2F;
    localparam logic [7:0] OP_DISC     = 8'h50;
    localparam logic [7:0] OP_TRACK    = 8'h2D;
    localparam logic [7:0] OP_PLAY     = 8'hE0;
    localparam logic [7:0] ARG_00      = 8'h00;
    localparam logic [7:0] ARG_01      = 8'h01;
    localparam logic [7:0] ARG_08      = 8'h08;
    localparam logic [7:0] ARG_40      = 8'h40;
    localparam logic [7:0] ARG_41      = 8'h41;

    localparam logic [47:0] CART_RESET = 48'h00FCFF4AFCFF;

    localparam logic [3:0] PLAY_LEN = 4'd9;
    localparam logic [2:0] CART_LEN = 3'd6;

    // Play info slots that commands touch
    localparam int PI_MODE_A = 1;
    localparam int PI_DISC   = 3;
    localparam int PI_TRACK  = 5;
    localparam int PI_MODE_B = 8;

    typedef logic [8:0][7:0] play_t;
    typedef logic [4:0][7:0] hist_t;   // entry 0 is the newest
    typedef logic [5:0][7:0] cart_t;   // entry 5 is sent first

    localparam play_t PLAY_RESET = {8'h02, 8'h0A, 8'hC7, 8'h01, 8'h80,
                                    8'h01, 8'h00, 8'h02, 8'h00};

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ARM,
        CMD_DISARM,
        CMD_CART,
        CMD_POWER_DOWN,
        CMD_START,
        CMD_DISC_DN,
        CMD_DISC_UP,
        CMD_TRACK_DN,
        CMD_TRACK_UP,
        CMD_PLAY_INFO
    } cmd_t;

    typedef struct packed {
        logic       data_release;
        logic       byte_done;
        logic [7:0] last_byte;
        logic [7:0] disc_number;
        logic [7:0] track_number;
    } result_t;

endpackage

FILE: src/sbcd_match.sv
// Priority decoder of command patterns in the byte history.
module sbcd_match (
    input  sbcd_pkg::hist_t hist,
    input  logic            id_armed,
    output sbcd_pkg::cmd_t  cmd
);
    import sbcd_pkg::*;

    logic a0, a2, a3, a4;

    always_comb
    begin
        a0 = hist[0] inside {ADDR_A0, ADDR_A1};
        a2 = hist[2] inside {ADDR_A0, ADDR_A1};
        a3 = hist[3] inside {ADDR_A0, ADDR_A1};
        a4 = hist[4] inside {ADDR_A0, ADDR_A1};

        if (hist[2] == HDR_ARM_A && hist[1] inside {ID_MAIN_0, ID_MAIN_1}
            && hist[0] == OP_ARM_MAIN)
            cmd = CMD_ARM;
        else if (hist[2] == HDR_ARM_B && hist[1] inside {ID_ALT_0, ID_ALT_1}
                 && hist[0] == OP_ARM_ALT)
            cmd = CMD_ARM;
        else if (a0 && id_armed)
            cmd = CMD_DISARM;
        else if (a2 && hist[1] inside {ID_CART_0, ID_CART_1} && hist[0] == OP_CART)
            cmd = CMD_CART;
        else if (a2 && hist[1] inside {ID_PWR_0, ID_PWR_1} && hist[0] == OP_PWR_DOWN)
            cmd = CMD_POWER_DOWN;
        else if (a2 && hist[1] inside {ID_PWR_0, ID_PWR_1} && hist[0] == OP_START)
            cmd = CMD_START;
        else if (a3 && hist[2] inside {ID_MAIN_0, ID_MAIN_1} && hist[1] == OP_DISC
                 && hist[0] == ARG_01)
            cmd = CMD_DISC_DN;
        else if (a3 && hist[2] inside {ID_MAIN_0, ID_MAIN_1} && hist[1] == OP_DISC
                 && hist[0] == ARG_41)
            cmd = CMD_DISC_UP;
        else if (a4 && hist[3] inside {ID_TRK_0, ID_TRK_1} && hist[2] == OP_TRACK
                 && hist[1] == ARG_00 && hist[0] == ARG_01)
            cmd = CMD_TRACK_DN;
        else if (a4 && hist[3] inside {ID_TRK_0, ID_TRK_1} && hist[2] == OP_TRACK
                 && hist[1] == ARG_40 && hist[0] == ARG_01)
            cmd = CMD_TRACK_UP;
        else if (a4 && hist[3] inside {ID_TRK_0, ID_TRK_1} && hist[2] == OP_PLAY
                 && hist[1] == ARG_01 && hist[0] == ARG_08)
            cmd = CMD_PLAY_INFO;
        else
            cmd = CMD_NONE;
    end

endmodule

FILE: src/sbcd_core.sv
// Responder state and the per-item bit, history and reply update.
module sbcd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic              req_type,
    input  logic              data_line,
    input  logic              cfg_wr_en,
    input  logic [47:0]       cfg_wr_data,
    output sbcd_pkg::result_t result
);
    import sbcd_pkg::*;

    logic [2:0]  bit_pos_reg, bit_pos_next;
    logic [7:0]  rx_reg, rx_next;
    logic [7:0]  tx_reg, tx_next;
    hist_t       hist_reg, hist_next;
    logic        id_armed_reg, id_armed_next;
    logic [3:0]  play_left_reg, play_left_next;
    logic [2:0]  cart_left_reg, cart_left_next;
    play_t       play_info_reg, play_info_next;
    cart_t       cart_reg;

    hist_t       hist_shift;
    cmd_t        cmd;
    logic [2:0]  bit_idx;
    logic        tx_bit;
    logic [7:0]  rx_sampled;
    logic [3:0]  play_idx;
    logic [2:0]  cart_idx;

    sbcd_match u_match (
        .hist     (hist_shift),
        .id_armed (id_armed_reg),
        .cmd      (cmd)
    );

    always_comb
    begin
        bit_idx    = ~bit_pos_reg;          // MSB first
        tx_bit     = tx_reg[bit_idx];
        rx_sampled = rx_reg;
        rx_sampled[bit_idx] = data_line & tx_bit;
        hist_shift = {hist_reg[3:0], (tx_reg != BYTE_IDLE) ? tx_reg : rx_sampled};
        play_idx   = '0;
        cart_idx   = '0;

        bit_pos_next   = bit_pos_reg;
        rx_next        = rx_reg;
        tx_next        = tx_reg;
        hist_next      = hist_reg;
        id_armed_next  = id_armed_reg;
        play_left_next = play_left_reg;
        cart_left_next = cart_left_reg;
        play_info_next = play_info_reg;
        result.data_release = 1'b1;
        result.byte_done    = 1'b0;

        if (req_type)
        begin
            bit_pos_next   = '0;
            tx_next        = BYTE_IDLE;
            play_left_next = '0;
            cart_left_next = '0;
        end
        else
        begin
            result.data_release = tx_bit;
            rx_next = rx_sampled;
            if (bit_pos_reg == 3'd7)
            begin
                result.byte_done = 1'b1;
                bit_pos_next     = '0;
                hist_next        = hist_shift;
                tx_next          = BYTE_IDLE;

                case (cmd)
                    CMD_ARM:        id_armed_next = 1'b1;
                    CMD_DISARM:
                    begin
                        id_armed_next = 1'b0;
                        tx_next       = REPLY_ID;
                    end
                    CMD_CART:       cart_left_next = CART_LEN;
                    CMD_POWER_DOWN:
                    begin
                        tx_next = REPLY_ACK;
                        play_info_next[PI_MODE_A] = MODE_STOP;
                        play_info_next[PI_MODE_B] = MODE_STOP;
                    end
                    CMD_START:
                    begin
                        tx_next = REPLY_ACK;
                        play_info_next[PI_MODE_A] = MODE_PLAY;
                        play_info_next[PI_MODE_B] = MODE_PLAY;
                    end
                    CMD_DISC_DN:
                    begin
                        play_info_next[PI_DISC]  = play_info_reg[PI_DISC] - 8'd1;
                        play_info_next[PI_TRACK] = 8'd1;
                    end
                    CMD_DISC_UP:
                    begin
                        play_info_next[PI_DISC]  = play_info_reg[PI_DISC] + 8'd1;
                        play_info_next[PI_TRACK] = 8'd1;
                    end
                    CMD_TRACK_DN:
                        play_info_next[PI_TRACK] = play_info_reg[PI_TRACK] - 8'd1;
                    CMD_TRACK_UP:
                        play_info_next[PI_TRACK] = play_info_reg[PI_TRACK] + 8'd1;
                    CMD_PLAY_INFO:  play_left_next = PLAY_LEN;
                    default:        ;
                endcase

                // queued reply bytes; counts past their lengths are dropped
                if (play_left_next > PLAY_LEN)
                    play_left_next = '0;
                if (cart_left_next > CART_LEN)
                    cart_left_next = '0;

                if (play_left_next != '0)
                begin
                    play_idx       = PLAY_LEN - play_left_next;
                    tx_next        = play_info_next[play_idx];
                    play_left_next = play_left_next - 4'd1;
                end
                else if (cart_left_next != '0)
                begin
                    cart_idx       = cart_left_next - 3'd1;
                    tx_next        = cart_reg[cart_idx];
                    cart_left_next = cart_left_next - 3'd1;
                end
            end
            else
            begin
                bit_pos_next = bit_pos_reg + 3'd1;
            end
        end

        result.last_byte    = hist_next[0];
        result.disc_number  = play_info_next[PI_DISC];
        result.track_number = play_info_next[PI_TRACK];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg   <= '0;
            rx_reg        <= '0;
            tx_reg        <= BYTE_IDLE;
            hist_reg      <= '0;
            id_armed_reg  <= 1'b0;
            play_left_reg <= '0;
            cart_left_reg <= '0;
            play_info_reg <= PLAY_RESET;
        end
        else if (step_en)
        begin
            bit_pos_reg   <= bit_pos_next;
            rx_reg        <= rx_next;
            tx_reg        <= tx_next;
            hist_reg      <= hist_next;
            id_armed_reg  <= id_armed_next;
            play_left_reg <= play_left_next;
            cart_left_reg <= cart_left_next;
            play_info_reg <= play_info_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cart_reg <= CART_RESET;
        else if (cfg_wr_en)
            cart_reg <= cfg_wr_data;
    end

endmodule

FILE: src/serial_bus_cd_changer_responder.sv
// Top level of the serial bus CD changer responder: input and result registers.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------------
//  in      | to block  | in_valid / in_stall | req_type, data_line
//  out     | from block| out_valid/out_stall | data_release, byte_done, last_byte,
//          |           |                     | disc_number, track_number
//  cfg     | to block  | cfg_wr_en           | cfg_wr_data (cartridge info bytes)
//
// One transfer per cycle sustained while out_stall stays low; an input transfer passes
// through the input register and then the result register. The rate is set by the
// responder state update, which finishes an item combinationally between the two.
// Reset (rst_n low, asynchronous) restores the power-up responder state and
// the default cartridge info bytes; both pipeline registers come up empty.
// A stalled result holds its register; the input register keeps taking one
// more item and then raises in_stall until the result moves on.
module serial_bus_cd_changer_responder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic        data_line,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        data_release,
    output logic        byte_done,
    output logic [7:0]  last_byte,
    output logic [7:0]  disc_number,
    output logic [7:0]  track_number,
    input  logic        cfg_wr_en,
    input  logic [47:0] cfg_wr_data
);
    import sbcd_pkg::*;

    // input register
    logic    s1_valid_reg, s1_valid_next;
    logic    s1_req_reg;
    logic    s1_line_reg;
    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    result_t step_res;
    logic    in_take;
    logic    advance;

    // an item moves on whenever the result register is empty or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    sbcd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .req_type    (s1_req_reg),
        .data_line   (s1_line_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (step_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg && out_stall;
        if (advance)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg  <= req_type;
            s1_line_reg <= data_line;
        end
        if (advance)
            out_res_reg <= step_res;
    end

    assign out_valid    = out_valid_reg;
    assign data_release = out_res_reg.data_release;
    assign byte_done    = out_res_reg.byte_done;
    assign last_byte    = out_res_reg.last_byte;
    assign disc_number  = out_res_reg.disc_number;
    assign track_number = out_res_reg.track_number;

endmodule

FILE: src/sbcd_checker.sv
// Port-level checks of the responder pipeline, bound to the top level.
module sbcd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       data_release,
    input logic       byte_done,
    input logic [7:0] last_byte,
    input logic [7:0] disc_number,
    input logic [7:0] track_number
);

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_release)
            && $stable(byte_done) && $stable(last_byte)
            && $stable(disc_number) && $stable(track_number))
        else $error("stalled result changed");

    // input backs up only behind a stalled, full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // a fresh result follows an input transfer through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a matching input transfer");

endmodule

bind serial_bus_cd_changer_responder sbcd_checker u_sbcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_release (data_release),
    .byte_done    (byte_done),
    .last_byte    (last_byte),
    .disc_number  (disc_number),
    .track_number (track_number)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the serial bus CD changer responder.
`timescale 1ns / 1ps

module tb;
    import sbcd_pkg::*;

    // ------------------------------------------------------------------
    // Run limits
    // ------------------------------------------------------------------
    // Slowest legal run: about 1800 transfers, each one possibly waiting
    // out a long sender gap and a long receiver stall. Several times that.
    localparam int CYCLE_LIMIT     = 200_000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int TAIL_CYCLES     = 8;     // margin past the result latency

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic        clk          = 1'b0;
    logic        rst_n;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        req_type     = 1'b0;
    logic        data_line    = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        data_release;
    logic        byte_done;
    logic [7:0]  last_byte;
    logic [7:0]  disc_number;
    logic [7:0]  track_number;
    logic        cfg_wr_en    = 1'b0;
    logic [47:0] cfg_wr_data  = '0;

    serial_bus_cd_changer_responder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .data_line    (data_line),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_release (data_release),
        .byte_done    (byte_done),
        .last_byte    (last_byte),
        .disc_number  (disc_number),
        .track_number (track_number),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    result_t expected_responses[$];
    int      mismatches    = 0;
    int      items_sent    = 0;
    int      cycle_count   = 0;
    int      send_gap_pct  = 0;   // chance per cycle that the sender holds off
    int      stall_pct     = 0;   // chance per cycle that the receiver stalls

    // ------------------------------------------------------------------
    // Responder predictor state
    // ------------------------------------------------------------------
    logic [2:0] bit_slot;          // 0 means bit 7 goes out next
    logic [7:0] rx_shift;          // bits sampled off the wired-AND line
    logic [7:0] reply_byte;        // byte being driven, BYTE_IDLE when silent
    hist_t      bus_history;       // entry 0 is the newest byte
    logic       ident_armed;
    logic [3:0] play_remaining;
    logic [2:0] cart_remaining;
    play_t      play_buf;
    cart_t      cart_words;        // entry 5 goes out first

    task automatic responder_reset();
        bit_slot       = '0;
        rx_shift       = '0;
        reply_byte     = BYTE_IDLE;
        bus_history    = '0;
        ident_armed    = 1'b0;
        play_remaining = '0;
        cart_remaining = '0;
        play_buf       = PLAY_RESET;
        cart_words     = CART_RESET;
    endtask

    function automatic logic one_of(input logic [7:0] b, input logic [7:0] x,
                                    input logic [7:0] y);
        return b == x || b == y;
    endfunction

    // Pattern match over the history, highest priority first.
    function automatic cmd_t decode_history();
        logic addr2;
        logic addr3;
        logic addr4;
        addr2 = one_of(bus_history[2], ADDR_A0, ADDR_A1);
        addr3 = one_of(bus_history[3], ADDR_A0, ADDR_A1);
        addr4 = one_of(bus_history[4], ADDR_A0, ADDR_A1);
        if (bus_history[2] == HDR_ARM_A && one_of(bus_history[1], ID_MAIN_0, ID_MAIN_1)
            && bus_history[0] == OP_ARM_MAIN)
            return CMD_ARM;
        if (bus_history[2] == HDR_ARM_B && one_of(bus_history[1], ID_ALT_0, ID_ALT_1)
            && bus_history[0] == OP_ARM_ALT)
            return CMD_ARM;
        if (one_of(bus_history[0], ADDR_A0, ADDR_A1) && ident_armed)
            return CMD_DISARM;
        if (addr2 && one_of(bus_history[1], ID_CART_0, ID_CART_1)
            && bus_history[0] == OP_CART)
            return CMD_CART;
        if (addr2 && one_of(bus_history[1], ID_PWR_0, ID_PWR_1)
            && bus_history[0] == OP_PWR_DOWN)
            return CMD_POWER_DOWN;
        if (addr2 && one_of(bus_history[1], ID_PWR_0, ID_PWR_1)
            && bus_history[0] == OP_START)
            return CMD_START;
        if (addr3 && one_of(bus_history[2], ID_MAIN_0, ID_MAIN_1)
            && bus_history[1] == OP_DISC && bus_history[0] == ARG_01)
            return CMD_DISC_DN;
        if (addr3 && one_of(bus_history[2], ID_MAIN_0, ID_MAIN_1)
            && bus_history[1] == OP_DISC && bus_history[0] == ARG_41)
            return CMD_DISC_UP;
        if (addr4 && one_of(bus_history[3], ID_TRK_0, ID_TRK_1) && bus_history[2] == OP_TRACK
            && bus_history[1] == ARG_00 && bus_history[0] == ARG_01)
            return CMD_TRACK_DN;
        if (addr4 && one_of(bus_history[3], ID_TRK_0, ID_TRK_1) && bus_history[2] == OP_TRACK
            && bus_history[1] == ARG_40 && bus_history[0] == ARG_01)
            return CMD_TRACK_UP;
        if (addr4 && one_of(bus_history[3], ID_TRK_0, ID_TRK_1) && bus_history[2] == OP_PLAY
            && bus_history[1] == ARG_01 && bus_history[0] == ARG_08)
            return CMD_PLAY_INFO;
        return CMD_NONE;
    endfunction

    // Advance the predictor by one bus event and return the response it implies.
    function automatic result_t predict_response(input logic req, input logic line);
        result_t    r;
        logic [2:0] bit_idx;
        r.data_release = 1'b1;
        r.byte_done    = 1'b0;
        if (req)
        begin
            // bus idle: realign to bit 7 and drop any queued reply
            bit_slot       = '0;
            reply_byte     = BYTE_IDLE;
            play_remaining = '0;
            cart_remaining = '0;
        end
        else
        begin
            bit_idx           = 3'd7 - bit_slot;
            r.data_release    = reply_byte[bit_idx];
            rx_shift[bit_idx] = line & r.data_release;
            if (bit_slot == 3'd7)
            begin
                r.byte_done = 1'b1;
                // what we sent wins over what we heard
                if (reply_byte != BYTE_IDLE)
                begin
                    bus_history = {bus_history[3:0], reply_byte};
                    reply_byte  = BYTE_IDLE;
                end
                else
                    bus_history = {bus_history[3:0], rx_shift};
                bit_slot = '0;
                case (decode_history())
                    CMD_ARM:        ident_armed = 1'b1;
                    CMD_DISARM:
                    begin
                        ident_armed = 1'b0;
                        reply_byte  = REPLY_ID;
                    end
                    CMD_CART:       cart_remaining = CART_LEN;
                    CMD_POWER_DOWN:
                    begin
                        reply_byte          = REPLY_ACK;
                        play_buf[PI_MODE_A] = MODE_STOP;
                        play_buf[PI_MODE_B] = MODE_STOP;
                    end
                    CMD_START:
                    begin
                        reply_byte          = REPLY_ACK;
                        play_buf[PI_MODE_A] = MODE_PLAY;
                        play_buf[PI_MODE_B] = MODE_PLAY;
                    end
                    CMD_DISC_DN:
                    begin
                        play_buf[PI_DISC]  = play_buf[PI_DISC] - 8'd1;
                        play_buf[PI_TRACK] = 8'h01;
                    end
                    CMD_DISC_UP:
                    begin
                        play_buf[PI_DISC]  = play_buf[PI_DISC] + 8'd1;
                        play_buf[PI_TRACK] = 8'h01;
                    end
                    CMD_TRACK_DN:   play_buf[PI_TRACK] = play_buf[PI_TRACK] - 8'd1;
                    CMD_TRACK_UP:   play_buf[PI_TRACK] = play_buf[PI_TRACK] + 8'd1;
                    CMD_PLAY_INFO:  play_remaining = PLAY_LEN;
                    default:        ;
                endcase
                // queued reply bytes override an ack or ID answer
                if (play_remaining != 0)
                begin
                    reply_byte     = play_buf[PLAY_LEN - play_remaining];
                    play_remaining = play_remaining - 4'd1;
                end
                else if (cart_remaining != 0)
                begin
                    reply_byte     = cart_words[cart_remaining - 3'd1];
                    cart_remaining = cart_remaining - 3'd1;
                end
            end
            else
                bit_slot = bit_slot + 3'd1;
        end
        r.last_byte    = bus_history[0];
        r.disc_number  = play_buf[PI_DISC];
        r.track_number = play_buf[PI_TRACK];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input logic req, input logic line,
                             input logic use_given = 1'b0, input result_t given = '0);
        result_t predicted;
        while ($urandom_range(1, 100) <= send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        data_line <= line;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer taken at this edge
        predicted = predict_response(req, line);
        expected_responses.push_back(use_given ? given : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // Host drives a byte MSB first; 1 bits leave the line released.
    task automatic send_byte(input logic [7:0] value);
        for (int b = 7; b >= 0; b--)
            send_item(1'b0, value[b]);
    endtask

    task automatic drain_responses();
        in_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] either(input logic [7:0] a, input logic [7:0] b);
        return $urandom_range(0, 1) ? b : a;
    endfunction

    // Mostly well-formed commands with random variants and reply reads,
    // the rest stray bytes, cut-off bytes and lone edges.
    task automatic random_burst();
        logic [7:0] seq[$];
        logic [7:0] addr;
        cmd_t       kind;
        int         reads;
        int         sel;
        sel  = $urandom_range(1, 100);
        addr = either(ADDR_A0, ADDR_A1);
        if (sel <= 75)
        begin
            kind  = cmd_t'($urandom_range(CMD_ARM, CMD_PLAY_INFO));
            reads = $urandom_range(0, 2);
            case (kind)
                CMD_ARM:
                begin
                    if ($urandom_range(0, 1))
                        seq = '{HDR_ARM_A, either(ID_MAIN_0, ID_MAIN_1), OP_ARM_MAIN};
                    else
                        seq = '{HDR_ARM_B, either(ID_ALT_0, ID_ALT_1), OP_ARM_ALT};
                    // follow up with an address byte to pull the ID answer
                    if ($urandom_range(0, 1))
                        seq.push_back(addr);
                end
                CMD_DISARM:     seq = '{addr};
                CMD_CART:
                begin
                    seq   = '{addr, either(ID_CART_0, ID_CART_1), OP_CART};
                    reads = $urandom_range(0, 7);
                end
                CMD_POWER_DOWN: seq = '{addr, either(ID_PWR_0, ID_PWR_1), OP_PWR_DOWN};
                CMD_START:      seq = '{addr, either(ID_PWR_0, ID_PWR_1), OP_START};
                CMD_DISC_DN:    seq = '{addr, either(ID_MAIN_0, ID_MAIN_1), OP_DISC, ARG_01};
                CMD_DISC_UP:    seq = '{addr, either(ID_MAIN_0, ID_MAIN_1), OP_DISC, ARG_41};
                CMD_TRACK_DN:
                    seq = '{addr, either(ID_TRK_0, ID_TRK_1), OP_TRACK, ARG_00, ARG_01};
                CMD_TRACK_UP:
                    seq = '{addr, either(ID_TRK_0, ID_TRK_1), OP_TRACK, ARG_40, ARG_01};
                default:
                begin
                    seq   = '{addr, either(ID_TRK_0, ID_TRK_1), OP_PLAY, ARG_01, ARG_08};
                    reads = $urandom_range(0, 10);
                end
            endcase
            foreach (seq[i])
                // now and then a corrupted byte breaks the command
                send_byte($urandom_range(0, 19) == 0 ? 8'($urandom) : seq[i]);
            repeat (reads)
                send_byte(BYTE_IDLE);
            if ($urandom_range(0, 3) == 0)
                send_item(1'b1, 1'($urandom));
        end
        else if (sel <= 87)
            send_byte(8'($urandom));
        else if (sel <= 95)
        begin
            // partial byte, then the bus goes idle
            repeat ($urandom_range(1, 7))
                send_item(1'b0, 1'($urandom));
            send_item(1'b1, 1'($urandom));
        end
        else
            send_item(1'($urandom), 1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Directed table: one row per bus byte or idle. A row with its flag set
    // gives the response of its final transfer outright; the rest rely on
    // the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic       idle;
        logic [3:0] nbits;
        logic [7:0] value;
        logic       typed;
        result_t    want;
    } bus_step_t;

    localparam result_t   PREDICTED = '0;
    localparam result_t   ACK_READ  = '{1'b0, 1'b1, 8'h00, 8'h01, 8'h01};
    localparam result_t   ID_READ   = '{1'b0, 1'b1, 8'hEE, 8'h00, 8'h00};
    localparam int        NUM_STEPS = 65;

    localparam bus_step_t DIRECTED_STEPS [NUM_STEPS] = '{
        // idle right after reset, then all-zero and all-one bytes
        '{1'b1, 4'd0, BYTE_IDLE,   1'b1, '{1'b1, 1'b0, 8'h00, 8'h01, 8'h01}},
        '{1'b0, 4'd8, 8'h00,       1'b1, '{1'b1, 1'b1, 8'h00, 8'h01, 8'h01}},
        '{1'b0, 4'd8, 8'hFF,       1'b1, '{1'b1, 1'b1, 8'hFF, 8'h01, 8'h01}},
        // byte cut short by idle; history survives
        '{1'b0, 4'd3, ADDR_A0,     1'b0, PREDICTED},
        '{1'b1, 4'd0, BYTE_IDLE,   1'b1, '{1'b1, 1'b0, 8'hFF, 8'h01, 8'h01}},
        // power down, then clock out the ack
        '{1'b0, 4'd8, ADDR_A0,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_PWR_0,    1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_PWR_DOWN, 1'b0, PREDICTED},
        '{1'b0, 4'd8, BYTE_IDLE,   1'b1, ACK_READ},
        // start
        '{1'b0, 4'd8, ADDR_A1,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_PWR_1,    1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_START,    1'b0, PREDICTED},
        '{1'b0, 4'd8, BYTE_IDLE,   1'b1, ACK_READ},
        // disc down twice wraps below zero, disc up wraps back
        '{1'b0, 4'd8, ADDR_A0,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_MAIN_0,   1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_DISC,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_01,      1'b1, '{1'b1, 1'b1, 8'h01, 8'h00, 8'h01}},
        '{1'b0, 4'd8, ADDR_A1,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_MAIN_1,   1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_DISC,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_01,      1'b1, '{1'b1, 1'b1, 8'h01, 8'hFF, 8'h01}},
        '{1'b0, 4'd8, ADDR_A0,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_MAIN_1,   1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_DISC,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_41,      1'b1, '{1'b1, 1'b1, 8'h41, 8'h00, 8'h01}},
        // track down twice wraps, track up wraps back
        '{1'b0, 4'd8, ADDR_A0,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_TRK_0,    1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_TRACK,    1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_00,      1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_01,      1'b1, '{1'b1, 1'b1, 8'h01, 8'h00, 8'h00}},
        '{1'b0, 4'd8, ADDR_A1,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_TRK_1,    1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_TRACK,    1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_00,      1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_01,      1'b1, '{1'b1, 1'b1, 8'h01, 8'h00, 8'hFF}},
        '{1'b0, 4'd8, ADDR_A0,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_TRK_0,    1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_TRACK,    1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_40,      1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_01,      1'b1, '{1'b1, 1'b1, 8'h01, 8'h00, 8'h00}},
        // play info request, reply cut short by idle
        '{1'b0, 4'd8, ADDR_A0,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_TRK_1,    1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_PLAY,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_01,      1'b0, PREDICTED},
        '{1'b0, 4'd8, ARG_08,      1'b0, PREDICTED},
        '{1'b0, 4'd8, BYTE_IDLE,   1'b0, PREDICTED},
        '{1'b0, 4'd8, BYTE_IDLE,   1'b0, PREDICTED},
        '{1'b0, 4'd8, BYTE_IDLE,   1'b0, PREDICTED},
        '{1'b1, 4'd0, BYTE_IDLE,   1'b0, PREDICTED},
        // cartridge info request, cut short by idle
        '{1'b0, 4'd8, ADDR_A1,     1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_CART_0,   1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_CART,     1'b0, PREDICTED},
        '{1'b0, 4'd8, BYTE_IDLE,   1'b0, PREDICTED},
        '{1'b0, 4'd8, BYTE_IDLE,   1'b0, PREDICTED},
        '{1'b1, 4'd0, BYTE_IDLE,   1'b0, PREDICTED},
        // arm through the main header; an address byte then draws the ID answer
        '{1'b0, 4'd8, HDR_ARM_A,   1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_MAIN_0,   1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_ARM_MAIN, 1'b0, PREDICTED},
        '{1'b0, 4'd8, ADDR_A0,     1'b0, PREDICTED},
        '{1'b0, 4'd8, BYTE_IDLE,   1'b1, ID_READ},
        // same through the alternate header
        '{1'b0, 4'd8, HDR_ARM_B,   1'b0, PREDICTED},
        '{1'b0, 4'd8, ID_ALT_1,    1'b0, PREDICTED},
        '{1'b0, 4'd8, OP_ARM_ALT,  1'b0, PREDICTED},
        '{1'b0, 4'd8, ADDR_A1,     1'b0, PREDICTED},
        '{1'b0, 4'd8, BYTE_IDLE,   1'b1, ID_READ}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        bus_step_t   row;
        logic [47:0] cart_value;
        int          items_goal;
        rst_n = 1'b0;
        responder_reset();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_STEPS[i])
        begin
            row = DIRECTED_STEPS[i];
            if (row.idle)
                send_item(1'b1, 1'b0, row.typed, row.want);
            else
                for (int b = 0; b < row.nbits; b++)
                    send_item(1'b0, row.value[7 - b], row.typed && b == row.nbits - 1,
                              row.want);
        end

        // Phases differ in handshake pressure and cartridge bytes; the first
        // keeps the reset cartridge value.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_gap_pct = 0;  stall_pct = 0;  end
                1:       begin send_gap_pct = 63; stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  stall_pct = 63; end
                default: begin send_gap_pct = 16; stall_pct = 16; end
            endcase
            if (phase != 0)
            begin
                // block is idle once every response is back
                drain_responses();
                case (phase)
                    1:       cart_value = '1;
                    2:       cart_value = '0;
                    default: cart_value = {$urandom, $urandom};
                endcase
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= cart_value;
                cart_words   = cart_value;
                @(negedge clk);
                cfg_wr_en <= 1'b0;
            end
            items_goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < items_goal)
                random_burst();
        end

        drain_responses();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_responses.size() == 0)
            $display("serial_bus_cd_changer_responder verification clean");
        else
            $display("serial_bus_cd_changer_responder verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, and response checking at the rising edge
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(1, 100) <= stall_pct);

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : response_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_responses.size() == 0)
            begin
                $display("%0t: response with none expected, got %h", $time,
                         {data_release, byte_done, last_byte, disc_number, track_number});
                mismatches++;
            end
            else
            begin
                want = expected_responses.pop_front();
                compare_field("data_release", 8'(want.data_release), 8'(data_release));
                compare_field("byte_done", 8'(want.byte_done), 8'(byte_done));
                compare_field("last_byte", want.last_byte, last_byte);
                compare_field("disc_number", want.disc_number, disc_number);
                compare_field("track_number", want.track_number, track_number);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("serial_bus_cd_changer_responder verification failed");
            $finish;
        end
    end

endmodule

FILE: filelist.f
src/sbcd_pkg.sv
src/sbcd_match.sv
src/sbcd_core.sv
src/serial_bus_cd_changer_responder.sv
src/sbcd_checker.sv
tb/sv/tb.sv
